[hw/rtl/ptest_pkg.sv]
// shared types and modular helper functions for the primality tester
package ptest_pkg;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        go;
    logic [63:0] x;
    logic [63:0] m;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic        go;
    logic [63:0] n;
  } sq_req_t;

  typedef struct packed {
    logic done;
    logic is_sq;
  } sq_rsp_t;

  // (x + y) mod m for x, y < m
  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [65:0] s;
    logic [65:0] t;
    s = {2'b00, x} + {2'b00, y};
    t = s - {2'b00, m};
    return t[65] ? s[63:0] : t[63:0];
  endfunction

  // x / 2 mod odd m, x < m
  function automatic logic [63:0] half_mod(input logic [63:0] x, input logic [63:0] m);
    logic [63:0] h;
    h = {1'b0, x[63:1]};
    return x[0] ? h + {1'b0, m[63:1]} + 64'd1 : h;
  endfunction

endpackage

[hw/rtl/primality_test_64bit_core.sv]
// top level: sequencer for the Baillie-PSW style 64-bit primality test
// Small or even values finish early. Every modular product goes through one bit-serial
// multiplier: a Miller-Rabin round needs up to about 126 products, the Lucas stage up to five
// per bit of n+1, and each reduction in the Jacobi search uses a bit-serial remainder unit.
// The input stalls for the whole test; the result sits in an output register so the next
// item can be taken meanwhile.
module primality_test_64bit_core import ptest_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_prime
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_M6   = 5'd2;
  localparam logic [4:0] S_MRI  = 5'd3;
  localparam logic [4:0] S_MRD  = 5'd4;
  localparam logic [4:0] S_PW   = 5'd5;
  localparam logic [4:0] S_PWV  = 5'd6;
  localparam logic [4:0] S_PWB  = 5'd7;
  localparam logic [4:0] S_MRC  = 5'd8;
  localparam logic [4:0] S_MRS  = 5'd9;
  localparam logic [4:0] S_SQ   = 5'd10;
  localparam logic [4:0] S_DM   = 5'd11;
  localparam logic [4:0] S_JL   = 5'd12;
  localparam logic [4:0] S_JM   = 5'd13;
  localparam logic [4:0] S_LT   = 5'd14;
  localparam logic [4:0] S_L0   = 5'd15;
  localparam logic [4:0] S_L1   = 5'd16;
  localparam logic [4:0] S_L2   = 5'd17;
  localparam logic [4:0] S_L3   = 5'd18;
  localparam logic [4:0] S_L4   = 5'd19;
  localparam logic [4:0] S_L5   = 5'd20;
  localparam logic [4:0] S_FIN  = 5'd21;

  localparam logic [63:0] SixVal  = 64'd6;
  localparam logic [31:0] DStart  = 32'd5;

  logic [4:0]  state;
  logic [63:0] n;
  logic        res;
  logic        base3;
  logic [63:0] e;
  logic [63:0] b;
  logic [63:0] v;
  logic [5:0]  s_cnt;
  logic [5:0]  sq_left;
  logic        first;
  logic [63:0] ja;
  logic [63:0] jn;
  logic        jneg;
  logic [31:0] dmag;
  logic        dneg;
  logic [63:0] dm;
  logic [63:0] u;
  logic [63:0] u2;
  logic [63:0] t1;
  logic [63:0] v2;
  logic [63:0] k;
  logic [5:0]  lcnt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  sq_req_t  sq_req;
  sq_rsp_t  sq_rsp;

  logic [63:0] nm1;
  logic [63:0] dm_next;
  logic [63:0] l4_v2;
  logic [63:0] l5_u;
  logic [63:0] l5_v;
  logic        in_acc;

  ptest_mulmod u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  ptest_modrem u_mod (.clk(clk), .rst(rst), .req(mod_req), .rsp(mod_rsp));
  ptest_sqchk  u_sq  (.clk(clk), .rst(rst), .req(sq_req),  .rsp(sq_rsp));

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign nm1      = n - 64'd1;
  assign dm_next  = (dneg && mod_rsp.rem != 64'd0) ? n - mod_rsp.rem : mod_rsp.rem;
  assign l4_v2    = half_mod(add_mod(t1, mul_rsp.p, n), n);
  assign l5_u     = half_mod(add_mod(u2, v2, n), n);
  assign l5_v     = half_mod(add_mod(mul_rsp.p, v2, n), n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      mul_req.go  <= 1'b0;
      mod_req.go  <= 1'b0;
      sq_req.go   <= 1'b0;
    end else begin
      mul_req.go <= 1'b0;
      mod_req.go <= 1'b0;
      sq_req.go  <= 1'b0;
      // a finishing test refills the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            n     <= candidate;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (n < 64'd2) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else if (n == 64'd2 || n == 64'd3 || n == 64'd5 || n == 64'd11) begin
            res   <= 1'b1;
            state <= S_FIN;
          end else begin
            mod_req.go <= 1'b1;
            mod_req.x  <= n;
            mod_req.m  <= SixVal;
            state      <= S_M6;
          end
        end
        S_M6: begin
          if (mod_rsp.done) begin
            if (mod_rsp.rem == 64'd1 || mod_rsp.rem == 64'd5) begin
              base3 <= 1'b0;
              state <= S_MRI;
            end else begin
              res   <= 1'b0;
              state <= S_FIN;
            end
          end
        end
        S_MRI: begin
          e     <= nm1;
          s_cnt <= 6'd0;
          state <= S_MRD;
        end
        S_MRD: begin
          if (!e[0]) begin
            e     <= {1'b0, e[63:1]};
            s_cnt <= s_cnt + 6'd1;
          end else begin
            sq_left <= s_cnt - 6'd1;
            b       <= base3 ? 64'd3 : 64'd2;
            v       <= 64'd1;
            first   <= 1'b1;
            state   <= S_PW;
          end
        end
        S_PW: begin
          mul_req.m <= n;
          if (e == 64'd0) begin
            state <= S_MRC;
          end else if (e[0]) begin
            mul_req.go <= 1'b1;
            mul_req.a  <= v;
            mul_req.b  <= b;
            state      <= S_PWV;
          end else begin
            mul_req.go <= 1'b1;
            mul_req.a  <= b;
            mul_req.b  <= b;
            state      <= S_PWB;
          end
        end
        S_PWV: begin
          if (mul_rsp.done) begin
            v          <= mul_rsp.p;
            mul_req.go <= 1'b1;
            mul_req.a  <= b;
            mul_req.b  <= b;
            state      <= S_PWB;
          end
        end
        S_PWB: begin
          if (mul_rsp.done) begin
            b     <= mul_rsp.p;
            e     <= {1'b0, e[63:1]};
            state <= S_PW;
          end
        end
        S_MRC: begin
          // x == 1 only counts before the first squaring
          if (v == nm1 || (first && v == 64'd1)) begin
            if (!base3) begin
              base3 <= 1'b1;
              state <= S_MRI;
            end else begin
              sq_req.go <= 1'b1;
              sq_req.n  <= n;
              state     <= S_SQ;
            end
          end else if (sq_left == 6'd0) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else begin
            mul_req.go <= 1'b1;
            mul_req.a  <= v;
            mul_req.b  <= v;
            mul_req.m  <= n;
            sq_left    <= sq_left - 6'd1;
            first      <= 1'b0;
            state      <= S_MRS;
          end
        end
        S_MRS: begin
          if (mul_rsp.done) begin
            v     <= mul_rsp.p;
            state <= S_MRC;
          end
        end
        S_SQ: begin
          if (sq_rsp.done) begin
            if (sq_rsp.is_sq) begin
              res   <= 1'b0;
              state <= S_FIN;
            end else begin
              dmag       <= DStart;
              dneg       <= 1'b0;
              mod_req.go <= 1'b1;
              mod_req.x  <= {32'd0, DStart};
              mod_req.m  <= n;
              state      <= S_DM;
            end
          end
        end
        S_DM: begin
          if (mod_rsp.done) begin
            dm    <= dm_next;
            ja    <= dm_next;
            jn    <= n;
            jneg  <= 1'b0;
            state <= S_JL;
          end
        end
        S_JL: begin
          if (ja == 64'd0) begin
            if (jn != 64'd1) begin
              res   <= 1'b0;
              state <= S_FIN;
            end else if (jneg) begin
              u     <= 64'd1;
              v     <= 64'd1;
              k     <= n + 64'd1;
              lcnt  <= 6'd63;
              state <= S_LT;
            end else begin
              // next D: magnitude grows by two, sign alternates
              dmag       <= dmag + 32'd2;
              dneg       <= !dneg;
              mod_req.go <= 1'b1;
              mod_req.x  <= {32'd0, dmag + 32'd2};
              mod_req.m  <= n;
              state      <= S_DM;
            end
          end else if (!ja[0]) begin
            ja <= {1'b0, ja[63:1]};
            if (jn[2:0] == 3'd3 || jn[2:0] == 3'd5) begin
              jneg <= !jneg;
            end
          end else begin
            if (ja[1:0] == 2'd3 && jn[1:0] == 2'd3) begin
              jneg <= !jneg;
            end
            jn         <= ja;
            mod_req.go <= 1'b1;
            mod_req.x  <= jn;
            mod_req.m  <= ja;
            state      <= S_JM;
          end
        end
        S_JM: begin
          if (mod_rsp.done) begin
            ja    <= mod_rsp.rem;
            state <= S_JL;
          end
        end
        S_LT: begin
          // drop leading zeros and the top one of n+1
          k <= {k[62:0], 1'b0};
          if (k[63]) begin
            state <= S_L0;
          end else begin
            lcnt <= lcnt - 6'd1;
          end
        end
        S_L0: begin
          if (lcnt == 6'd0) begin
            res   <= (u == 64'd0);
            state <= S_FIN;
          end else begin
            mul_req.go <= 1'b1;
            mul_req.a  <= u;
            mul_req.b  <= v;
            mul_req.m  <= n;
            state      <= S_L1;
          end
        end
        S_L1: begin
          if (mul_rsp.done) begin
            u2         <= mul_rsp.p;
            mul_req.go <= 1'b1;
            mul_req.a  <= v;
            mul_req.b  <= v;
            state      <= S_L2;
          end
        end
        S_L2: begin
          if (mul_rsp.done) begin
            t1         <= mul_rsp.p;
            mul_req.go <= 1'b1;
            mul_req.a  <= u;
            mul_req.b  <= u;
            state      <= S_L3;
          end
        end
        S_L3: begin
          if (mul_rsp.done) begin
            mul_req.go <= 1'b1;
            mul_req.a  <= dm;
            mul_req.b  <= mul_rsp.p;
            state      <= S_L4;
          end
        end
        S_L4: begin
          if (mul_rsp.done) begin
            v2 <= l4_v2;
            if (k[63]) begin
              mul_req.go <= 1'b1;
              mul_req.a  <= dm;
              mul_req.b  <= u2;
              state      <= S_L5;
            end else begin
              u     <= u2;
              v     <= l4_v2;
              k     <= {k[62:0], 1'b0};
              lcnt  <= lcnt - 6'd1;
              state <= S_L0;
            end
          end
        end
        S_L5: begin
          if (mul_rsp.done) begin
            u     <= l5_u;
            v     <= l5_v;
            k     <= {k[62:0], 1'b0};
            lcnt  <= lcnt - 6'd1;
            state <= S_L0;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            is_prime  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_CHK)
    else $error("accepted item did not start the test");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && out_stall) |=> (state == S_FIN && out_valid))
    else $error("pending result overwritten");

  a_jacobi_inv: assert property (@(posedge clk) disable iff (rst)
    state == S_JL |-> (jn[0] && ja < jn))
    else $error("jacobi operands out of range");

endmodule

[hw/rtl/ptest_mulmod.sv]
// bit-serial modular multiplier, one multiplier bit per cycle
module ptest_mulmod import ptest_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] m;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [65:0] s;
  logic [65:0] t1;
  logic [65:0] t2;

  // 2*acc + bit*a stays below 3m, so one of three candidates is in range
  always_comb begin
    s  = {1'b0, acc, 1'b0} + (b[63] ? {2'b00, a} : 66'd0);
    t1 = s - {2'b00, m};
    t2 = s - {1'b0, m, 1'b0};
    if (!t2[65]) begin
      acc_next = t2[63:0];
    end else if (!t1[65]) begin
      acc_next = t1[63:0];
    end else begin
      acc_next = s[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        a    <= req.a;
        b    <= req.b;
        m    <= req.m;
        acc  <= 64'd0;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        b   <= {b[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

  a_mul_reduced: assert property (@(posedge clk) disable iff (rst) done |-> acc < m)
    else $error("modular product not reduced");

endmodule

[hw/rtl/ptest_modrem.sv]
// restoring remainder unit, one dividend bit per cycle
module ptest_modrem import ptest_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] x;
  logic [63:0] m;
  logic [63:0] rem;
  logic [65:0] diff;

  assign diff = {1'b0, rem, x[63]} - {2'b00, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        x    <= req.x;
        m    <= req.m;
        rem  <= 64'd0;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= diff[65] ? {rem[62:0], x[63]} : diff[63:0];
        x   <= {x[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (m == 64'd0 || rem < m))
    else $error("remainder not below divisor");

endmodule

[hw/rtl/ptest_sqchk.sv]
// perfect square check by bitwise integer square root on a 32x32 multiplier
module ptest_sqchk import ptest_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  sq_req_t req,
  output sq_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic        phase;
  logic        fin;
  logic        is_sq;
  logic [63:0] n;
  logic [31:0] r;
  logic [31:0] mask;
  logic [31:0] trial;
  logic [63:0] prod;

  assign trial = r | mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        n     <= req.n;
        r     <= 32'd0;
        mask  <= 32'h8000_0000;
        phase <= 1'b0;
        fin   <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (!fin) begin
          if (!phase) begin
            prod  <= {32'd0, trial} * {32'd0, trial};
            phase <= 1'b1;
          end else begin
            if (prod <= n) begin
              r <= trial;
            end
            mask  <= {1'b0, mask[31:1]};
            phase <= 1'b0;
            if (mask[0]) begin
              fin <= 1'b1;
            end
          end
        end else begin
          if (!phase) begin
            prod  <= {32'd0, r} * {32'd0, r};
            phase <= 1'b1;
          end else begin
            is_sq <= (prod == n);
            done  <= 1'b1;
            busy  <= 1'b0;
          end
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.is_sq = is_sq;

endmodule
